// ----- design/id3fp_pkg.sv -----
// Package: shared types, codes and constants of the ID3v2 frame parser.
`default_nettype none
package id3fp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned ID_W       = 32;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned SIZE_W     = 28;
    localparam int unsigned POS_W      = 29;
    localparam int unsigned HCNT_W     = 4;
    localparam int unsigned GROUP_BITS = 7;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [HCNT_W-1:0] HDR_LEN     = 4'd10;
    localparam logic [HCNT_W-1:0] HDR_LAST    = 4'd9;
    localparam logic [HCNT_W-1:0] HDR_VERSION = 4'd3;
    localparam logic [HCNT_W-1:0] HDR_SIZE0   = 4'd6;
    localparam logic [HCNT_W-1:0] FHDR_SIZE0  = 4'd4;
    localparam logic [HCNT_W-1:0] FHDR_FLAGS0 = 4'd8;

    localparam logic [KIND_W-1:0] KIND_INFO    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ALL = 1'b1;

    localparam logic [ID_W-1:0] TARGET_ID_RST = 32'h5449_5432;
    localparam logic            MATCH_ALL_RST = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              start_of_file;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   frame_id;
        logic [BYTE_W-1:0] data_byte;
        logic              last_of_frame;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0] target_id;
        logic            match_all;
    } t_cfg;

endpackage
`default_nettype wire

// ----- design/id3v2_frame_parser.sv -----
// Top level: ID3v2 frame parser with input and result registers.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | request   | i_in_valid / o_in_stall | i_in_item  (in_byte, sof)
//  out     | result    | o_out_valid / i_out_stall | o_out_item (kind, id, data, last)
//  cfg     | write     | i_cfg_we               | i_cfg_index, i_cfg_data
//
//  One byte per clock while the result is not stalled; each byte is held in the
//  input register and its result is then registered in the result register.
//  Throughput is set by the single parse step between the two registers.
//  Synchronous active-low reset; parsing starts with the first byte after it.
//  A stalled result holds the parse step; the input register then holds
//  one request and stall goes high.
`default_nettype none
module id3v2_frame_parser (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  id3fp_pkg::t_in_item                 i_in_item,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output id3fp_pkg::t_out_item                o_out_item,
    input  wire                                 i_cfg_we,
    input  wire  [id3fp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [id3fp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import id3fp_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      step;
    logic      res_valid;
    t_out_item res;
    t_cfg      cfg;

    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    id3fp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    id3fp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// ----- design/id3fp_cfg.sv -----
// Configuration registers: target frame ID and match-all mode.
`default_nettype none
module id3fp_cfg (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [id3fp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [id3fp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output id3fp_pkg::t_cfg                     o_cfg
);
    import id3fp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_id <= TARGET_ID_RST;
            r_cfg.match_all <= MATCH_ALL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TARGET_ID: r_cfg.target_id <= i_cfg_data[ID_W-1:0];
                CFG_MATCH_ALL: r_cfg.match_all <= i_cfg_data[0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- design/id3fp_core.sv -----
// Parse core: tag and frame header walk, payload selection, one byte per step.
`default_nettype none
module id3fp_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  id3fp_pkg::t_in_item  i_item,
    input  id3fp_pkg::t_cfg      i_cfg,
    output logic                 o_res_valid,
    output id3fp_pkg::t_out_item o_res
);
    import id3fp_pkg::*;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_FRAME,
        PH_PAYLOAD,
        PH_STOP
    } t_phase;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    t_phase             r_phase,    n_phase,    c_phase;
    logic [HCNT_W-1:0]  r_hcnt,     n_hcnt,     c_hcnt;
    logic [ID_W-1:0]    r_id,       n_id,       c_id;
    logic [SIZE_W-1:0]  r_acc,      n_acc,      c_acc;
    logic [POS_W-1:0]   r_tag_end,  n_tag_end,  c_tag_end;
    logic [POS_W-1:0]   r_pos,      n_pos,      c_pos;
    logic [SIZE_W-1:0]  r_left,     n_left,     c_left;
    logic               r_matched,  n_matched,  c_matched;
    logic [SIZE_W-1:0]  acc_shift;
    logic [SIZE_W-1:0]  left_dec;
    logic [BYTE_W-1:0]  b;

    assign b = i_item.in_byte;

    always_comb begin
        c_phase   = r_phase;
        c_hcnt    = r_hcnt;
        c_id      = r_id;
        c_acc     = r_acc;
        c_tag_end = r_tag_end;
        c_pos     = r_pos;
        c_left    = r_left;
        c_matched = r_matched;
        if (i_item.start_of_file) begin
            c_phase   = PH_TAG;
            c_hcnt    = '0;
            c_id      = '0;
            c_acc     = '0;
            c_tag_end = '0;
            c_pos     = '0;
            c_left    = '0;
            c_matched = 1'b0;
        end

        acc_shift = {c_acc[SIZE_W-GROUP_BITS-1:0], b[GROUP_BITS-1:0]};
        left_dec  = c_left - SIZE_W'(1);

        n_phase     = c_phase;
        n_hcnt      = c_hcnt;
        n_id        = c_id;
        n_acc       = c_acc;
        n_tag_end   = c_tag_end;
        n_pos       = c_pos;
        n_left      = c_left;
        n_matched   = c_matched;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_INFO, frame_id: '0, data_byte: '0, last_of_frame: 1'b1};

        if (c_phase == PH_STOP) begin
            n_phase = PH_STOP;
        end else if (c_phase == PH_FRAME && c_hcnt == '0
                     && (c_pos >= c_tag_end || b == '0)) begin
            // stop on padding or tag end
            n_phase = PH_STOP;
        end else begin
            if (c_pos != POS_MAX) begin
                n_pos = c_pos + POS_W'(1);
            end
            unique case (c_phase)
                PH_TAG: begin
                    if (c_hcnt == HDR_VERSION) begin
                        o_res_valid     = 1'b1;
                        o_res.data_byte = b;
                    end
                    if (c_hcnt >= HDR_SIZE0) begin
                        n_acc = acc_shift;
                    end
                    n_hcnt = c_hcnt + HCNT_W'(1);
                    if (c_hcnt == HDR_LAST) begin
                        n_tag_end = POS_W'(HDR_LEN) + {1'b0, acc_shift};
                        n_acc     = '0;
                        n_hcnt    = '0;
                        n_phase   = PH_FRAME;
                    end
                end
                PH_FRAME: begin
                    if (c_hcnt < FHDR_SIZE0) begin
                        n_id = {c_id[ID_W-BYTE_W-1:0], b};
                    end else if (c_hcnt < FHDR_FLAGS0) begin
                        n_acc = acc_shift;
                    end
                    n_hcnt = c_hcnt + HCNT_W'(1);
                    if (c_hcnt == HDR_LAST) begin
                        n_hcnt    = '0;
                        n_matched = i_cfg.match_all || (c_id == i_cfg.target_id);
                        n_left    = c_acc;
                        n_acc     = '0;
                        if (c_acc == '0) begin
                            if (n_matched) begin
                                o_res_valid    = 1'b1;
                                o_res.kind     = KIND_EMPTY;
                                o_res.frame_id = c_id;
                            end
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_left = left_dec;
                    if (c_matched) begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_PAYLOAD;
                        o_res.frame_id      = c_id;
                        o_res.data_byte     = b;
                        o_res.last_of_frame = (left_dec == '0);
                    end
                    if (left_dec == '0) begin
                        n_phase = PH_FRAME;
                        n_id    = '0;
                    end
                end
                default: n_phase = PH_STOP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TAG;
            r_hcnt    <= '0;
            r_id      <= '0;
            r_acc     <= '0;
            r_tag_end <= '0;
            r_pos     <= '0;
            r_left    <= '0;
            r_matched <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_hcnt    <= n_hcnt;
            r_id      <= n_id;
            r_acc     <= n_acc;
            r_tag_end <= n_tag_end;
            r_pos     <= n_pos;
            r_left    <= n_left;
            r_matched <= n_matched;
        end
    end

`ifndef ASSERT_OFF
    a_hcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= HDR_LAST)
        else $error("header count out of range");
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_left != '0)
        else $error("payload phase with nothing left");
    a_stop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_STOP && !i_item.start_of_file |-> !o_res_valid)
        else $error("result while stopped");
    a_tag_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TAG |-> r_tag_end == '0)
        else $error("tag end set during tag header");
    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_STOP && !i_item.start_of_file |=> r_phase == PH_STOP)
        else $error("left stop without start of file");
`endif

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Testbench: ID3v2 frame parser driven with generated tag streams and checked per result.
`timescale 1ns / 100ps
module tb;
    import id3fp_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef enum logic [1:0] {TAG_HDR, FRAME_HDR, FRAME_BODY, HALTED} t_parse_phase;

    class tag_walk_model;
        logic [ID_W-1:0]   target;
        logic              take_all;
        t_parse_phase      phase;
        logic [HCNT_W-1:0] hdr_idx;
        logic [ID_W-1:0]   cur_id;
        logic [SIZE_W-1:0] size_acc;
        logic [POS_W-1:0]  tag_end;
        logic [POS_W-1:0]  file_pos;
        logic [SIZE_W-1:0] body_left;
        logic              matched;
        t_out_item         queued_emits[$];
        int                errors;

        function new();
            target   = TARGET_ID_RST;
            take_all = MATCH_ALL_RST;
            errors   = 0;
            restart();
        endfunction

        function void restart();
            phase     = TAG_HDR;
            hdr_idx   = '0;
            cur_id    = '0;
            size_acc  = '0;
            tag_end   = '0;
            file_pos  = '0;
            body_left = '0;
            matched   = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_TARGET_ID) begin
                target = data;
            end else begin
                take_all = data[0];
            end
        endfunction

        function void add_group(logic [BYTE_W-1:0] b);
            size_acc = {size_acc[SIZE_W-8:0], b[6:0]};
        endfunction

        function void queue_emit(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                 logic [BYTE_W-1:0] data, logic last);
            t_out_item e;
            e.kind          = kind;
            e.frame_id      = id;
            e.data_byte     = data;
            e.last_of_frame = last;
            queued_emits.push_back(e);
        endfunction

        // Return 1 when the byte is parsed, 0 when the parser is halted.
        function bit note_byte(t_in_item req);
            logic [BYTE_W-1:0] b;
            b = req.in_byte;
            if (req.start_of_file) restart();
            if (phase == HALTED) return 1'b0;
            if (phase == FRAME_HDR && hdr_idx == 0 && (file_pos >= tag_end || b == 0)) begin
                phase = HALTED;
                return 1'b1;
            end
            if (file_pos != '1) file_pos++;
            case (phase)
                TAG_HDR: begin
                    if (hdr_idx == HDR_VERSION) queue_emit(KIND_INFO, '0, b, 1'b1);
                    if (hdr_idx >= HDR_SIZE0) add_group(b);
                    hdr_idx++;
                    if (hdr_idx == HDR_LEN) begin
                        tag_end  = {1'b0, size_acc} + HDR_LEN;
                        size_acc = '0;
                        hdr_idx  = '0;
                        phase    = FRAME_HDR;
                    end
                end
                FRAME_HDR: begin
                    if (hdr_idx < FHDR_SIZE0) begin
                        cur_id = {cur_id[ID_W-9:0], b};
                    end else if (hdr_idx < FHDR_FLAGS0) begin
                        add_group(b);
                    end
                    hdr_idx++;
                    if (hdr_idx == HDR_LEN) begin
                        hdr_idx   = '0;
                        matched   = take_all || cur_id == target;
                        body_left = size_acc;
                        size_acc  = '0;
                        if (body_left == 0) begin
                            if (matched) queue_emit(KIND_EMPTY, cur_id, '0, 1'b1);
                        end else begin
                            phase = FRAME_BODY;
                        end
                    end
                end
                default: begin
                    body_left--;
                    if (matched) queue_emit(KIND_PAYLOAD, cur_id, b, body_left == 0);
                    if (body_left == 0) begin
                        phase  = FRAME_HDR;
                        cur_id = '0;
                    end
                end
            endcase
            return 1'b1;
        endfunction

        function void check_emit(t_out_item got);
            t_out_item want;
            if (queued_emits.size() == 0) begin
                $display("%0t: unexpected result %h, expected none", $time, got);
                errors++;
                return;
            end
            want = queued_emits.pop_front();
            if (got.kind !== want.kind) begin
                $display("%0t: kind expected %0d, got %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.frame_id !== want.frame_id) begin
                $display("%0t: frame_id expected %h, got %h", $time, want.frame_id,
                         got.frame_id);
                errors++;
            end
            if (got.data_byte !== want.data_byte) begin
                $display("%0t: data_byte expected %h, got %h", $time, want.data_byte,
                         got.data_byte);
                errors++;
            end
            if (got.last_of_frame !== want.last_of_frame) begin
                $display("%0t: last_of_frame expected %0d, got %0d", $time,
                         want.last_of_frame, got.last_of_frame);
                errors++;
            end
        endfunction

        function int pending();
            return queued_emits.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    tag_walk_model board = new();

    logic [BYTE_W-1:0] file_bytes[$];
    int                burst_left   = 0;
    bit                gaps_on      = 1'b1;
    int                sent_bytes   = 0;
    int                stall_style  = 0;
    int unsigned       stall_tick   = 0;
    int                idle_cycles  = 0;

    id3v2_frame_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_emit(o_out_item);
        stall_tick <= stall_tick + 1;
        case (stall_style)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 35);
            default: i_out_stall <= (stall_tick % 11) < 4;
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [BYTE_W-1:0] b, input logic sof);
        t_in_item req;
        req.in_byte       = b;
        req.start_of_file = sof;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall);
        void'(board.note_byte(req));
        sent_bytes++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [ID_W-1:0] tgt, input logic all);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TARGET_ID;
        i_cfg_data  <= tgt;
        @(posedge i_clk);
        board.set_reg(CFG_TARGET_ID, tgt);
        i_cfg_index <= CFG_MATCH_ALL;
        i_cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, all};
        @(posedge i_clk);
        board.set_reg(CFG_MATCH_ALL, {{(CFG_DATA_W-1){1'b0}}, all});
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] syncsafe(int unsigned v, bit dirty);
        logic [31:0] w;
        w = {1'b0, v[27:21], 1'b0, v[20:14], 1'b0, v[13:7], 1'b0, v[6:0]};
        if (dirty) w = w | ($urandom & 32'h8080_8080);
        return w;
    endfunction

    task automatic make_file(input logic [ID_W-1:0] want_id);
        logic [BYTE_W-1:0] body[$];
        logic [ID_W-1:0]   fid;
        logic [31:0]       w;
        int unsigned       style, fsize, tsize, k;
        file_bytes.delete();
        style = $urandom_range(0, 11);
        if (style == 0) begin
            repeat ($urandom_range(1, 24)) file_bytes.push_back(8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 6))
                0, 1: fid = want_id;
                2: fid = want_id ^ (32'h1 << $urandom_range(0, 31));
                3: fid = 32'h5450_4531;
                4: fid = 32'h4150_4943;
                5: fid = 32'hFFFF_FFFF;
                default: fid = $urandom;
            endcase
            if (fid[31:24] == 8'h00) fid[31:24] = 8'h54;
            k = $urandom_range(0, 9);
            fsize = (k < 2) ? 0 : (k < 8) ? $urandom_range(1, 8) : $urandom_range(9, 160);
            for (int i = 3; i >= 0; i--) body.push_back(fid[8*i +: 8]);
            w = syncsafe(fsize, $urandom_range(0, 3) == 0);
            for (int i = 3; i >= 0; i--) body.push_back(w[8*i +: 8]);
            repeat (2) body.push_back(8'($urandom));
            repeat (fsize) body.push_back(8'($urandom));
        end
        case (style)
            1: begin
                tsize = body.size() + $urandom_range(0, 20);
                k = $urandom_range(0, body.size());
                while (body.size() > k) void'(body.pop_back());
            end
            2, 3, 4, 5: begin
                repeat ($urandom_range(1, 6)) body.push_back(8'h00);
                tsize = body.size();
            end
            6, 7, 8: tsize = body.size();
            9: tsize = $urandom_range(0, body.size());
            10: tsize = body.size() + $urandom_range(1, 40);
            default: begin
                repeat ($urandom_range(1, 3)) body.push_back(8'h00);
                tsize = $urandom & 32'h0FFF_FFFF;
            end
        endcase
        if ($urandom_range(0, 7) == 0) begin
            repeat (3) file_bytes.push_back(8'($urandom));
        end else begin
            file_bytes.push_back(8'h49);
            file_bytes.push_back(8'h44);
            file_bytes.push_back(8'h33);
        end
        case ($urandom_range(0, 5))
            0: file_bytes.push_back(8'h00);
            1: file_bytes.push_back(8'hFF);
            2: file_bytes.push_back(8'($urandom));
            default: file_bytes.push_back(8'($urandom_range(2, 4)));
        endcase
        repeat (2) file_bytes.push_back(8'($urandom));
        w = syncsafe(tsize, $urandom_range(0, 3) == 0);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
        foreach (body[i]) file_bytes.push_back(body[i]);
        if (style >= 6 && style <= 10) begin
            file_bytes.push_back(8'hFF);
            file_bytes.push_back(8'hFB);
            repeat ($urandom_range(0, 8)) file_bytes.push_back(8'($urandom));
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] opening[$];
        logic [ID_W-1:0]   tgt;
        logic              all;
        bit                sof_first;
        opening = '{8'h49, 8'h44, 8'h33, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h8C,
                    8'h54, 8'h49, 8'h54, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
                    8'h00, 8'hFF};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (opening[i]) send_request(opening[i], 1'b0);
        for (int p = 0; p < 7; p++) begin
            drain_results();
            case (p)
                0: begin tgt = 32'h5449_5432; all = 1'b0; end
                1: begin tgt = 32'hFFFF_FFFF; all = 1'b0; end
                2: begin tgt = 32'h0000_0000; all = 1'b0; end
                3: begin
                    tgt = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                           8'($urandom_range(48, 90)), 8'($urandom_range(48, 90))};
                    all = 1'b0;
                end
                4: begin tgt = 32'h5441_4C42; all = 1'b1; end
                5: begin tgt = $urandom; all = 1'b0; end
                default: begin tgt = 32'h5449_5432; all = 1'b1; end
            endcase
            write_setting(tgt, all);
            stall_style = p % 3;
            gaps_on     = (p != 2);
            sent_bytes  = 0;
            while (sent_bytes < 200) begin
                make_file(tgt);
                sof_first = $urandom_range(0, 19) != 0;
                foreach (file_bytes[i]) send_request(file_bytes[i], i == 0 && sof_first);
            end
        end
        drain_results();
        repeat (4) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
